/* hdl/nca_pkg.sv */
package nca_pkg;

  // Fixed field widths of the item and result channels.
  localparam int COORD_W  = 16;
  localparam int CLU_IN_W = 4;
  localparam int DIM_IN_W = 4;
  localparam int CFG_W    = 5;
  localparam int ID_W     = 5;

  // Squared difference of two Q8.8 values is an unsigned Q16.16 value below 2^32;
  // the distance sums are unsigned Q24.16 and saturate.
  localparam int MAG_W = 16;
  localparam int SQ_W  = 32;
  localparam int SUM_W = 40;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_POINT = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_CLUSTER_COUNT   = 1'b0,
    REG_DIMENSION_COUNT = 1'b1
  } cfg_reg_t;

  // Enables for the arithmetic stages inside every cell.
  typedef struct packed {
    logic diff_en;
    logic sq_en;
    logic acc_en;
  } pipe_ctl_t;

endpackage

/* hdl/nca_ram.sv */
module nca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/nca_cell.sv */
module nca_cell import nca_pkg::*; #(
  parameter int CELL_ID  = 0,
  parameter int MAX_DIMS = 16,
  parameter int CIW      = 4,
  parameter int CNTW     = 5,
  localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [CNTW-1:0]           used_clusters,
  input  logic                      ld_en,
  input  logic [CLU_IN_W-1:0]       ld_cluster,
  input  logic                      rd_en,
  input  logic [AW-1:0]             addr,
  input  logic signed [COORD_W-1:0] item_value,
  input  pipe_ctl_t                 ctl,
  input  logic signed [COORD_W-1:0] p1_coord,
  input  logic                      tok_vld_i,
  input  logic                      tok_have_i,
  input  logic [SUM_W-1:0]          tok_sum_i,
  input  logic [CIW-1:0]            tok_idx_i,
  output logic                      tok_vld_o,
  output logic                      tok_have_o,
  output logic [SUM_W-1:0]          tok_sum_o,
  output logic [CIW-1:0]            tok_idx_o
);

  logic                      wr_en;
  logic                      in_use;
  logic signed [COORD_W-1:0] centroid;
  logic signed [COORD_W:0]   diff_nxt;
  logic signed [COORD_W:0]   diff_r;
  logic [MAG_W-1:0]          mag;
  logic [SQ_W-1:0]           sq_nxt;
  logic [SQ_W-1:0]           sq_r;
  logic [SUM_W:0]            acc_wide;
  logic [SUM_W-1:0]          sum_nxt;
  logic [SUM_W-1:0]          sum_r;
  logic                      take_own;
  logic                      tok_vld_r;
  logic                      tok_have_r;
  logic [SUM_W-1:0]          tok_sum_r;
  logic [CIW-1:0]            tok_idx_r;

  assign wr_en  = ld_en && (32'(ld_cluster) == 32'(CELL_ID));
  assign in_use = CNTW'(CELL_ID) < used_clusters;

  nca_ram #(
    .WIDTH (COORD_W),
    .DEPTH (MAX_DIMS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (item_value),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (centroid)
  );

  // Exact 17-bit difference, then its magnitude squared.
  assign diff_nxt = $signed({centroid[COORD_W-1], centroid})
                  - $signed({p1_coord[COORD_W-1], p1_coord});
  assign mag      = diff_r[COORD_W] ? MAG_W'(-diff_r) : MAG_W'(diff_r);
  assign sq_nxt   = SQ_W'(mag) * SQ_W'(mag);
  assign acc_wide = {1'b0, sum_r} + (SUM_W+1)'(sq_r);
  assign sum_nxt  = acc_wide[SUM_W] ? SUM_MAX : acc_wide[SUM_W-1:0];

  // Strictly smaller wins, so a tie keeps the lower index already in the token.
  assign take_own = in_use && (!tok_have_i || (sum_r < tok_sum_i));

  always_ff @(posedge clk) begin
    if (ctl.diff_en) begin
      diff_r <= diff_nxt;
    end
    if (ctl.sq_en) begin
      sq_r <= sq_nxt;
    end
    tok_have_r <= tok_have_i || in_use;
    tok_sum_r  <= take_own ? sum_r : tok_sum_i;
    tok_idx_r  <= take_own ? CIW'(CELL_ID) : tok_idx_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_i;
      if (tok_vld_i) begin
        sum_r <= '0;
      end else if (ctl.acc_en && in_use) begin
        sum_r <= sum_nxt;
      end
    end
  end

  assign tok_vld_o  = tok_vld_r;
  assign tok_have_o = tok_have_r;
  assign tok_sum_o  = tok_sum_r;
  assign tok_idx_o  = tok_idx_r;

endmodule

/* hdl/nearest_centroid_assign_unit.sv */
// Nearest-centroid assignment (k-means assignment step), Q8.8 signed coordinates.
// Input channel (in_valid / in_stall): a load transaction (opcode 0) writes one centroid
// component at cluster_index, dim_index; a point transaction (opcode 1) delivers one
// point component.  Every centroid in use adds its squared difference to its distance sum.
// The point transaction at the last configured dimension finishes the point.
// Result channel (out_valid / out_stall): the 1-based index of the nearest centroid; a tie
// keeps the lower index.  The user writes configuration through cfg_we / cfg_index / cfg_data
// only while the block is idle; the block itself does not enforce this.
// Throughput: load transactions and non-final point components are taken one per cycle
// while no search runs.  A finishing component raises in_stall until its search ends: four
// pipeline stages (store read, difference, square, accumulate), then the comparison token
// walks the chain of centroid cells, one cell per cycle, and the result is registered
// from the last cell.  A finishing transaction is held off while an earlier result waits.
// Reset clears the distance sums and the handshake state and sets both counts to one; the
// centroid store is not cleared.  While the receiver stalls, the result holds and other
// transactions are still taken.
module nearest_centroid_assign_unit import nca_pkg::*; #(
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_DIMS     = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic [CLU_IN_W-1:0]       in_cluster_index,
  input  logic [DIM_IN_W-1:0]       in_dim_index,
  input  logic signed [COORD_W-1:0] in_coord_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ID_W-1:0]           out_cluster_id
);

  localparam int AW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CIW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int CNTW = $clog2(MAX_CLUSTERS + 1);
  localparam int DCW  = $clog2(MAX_DIMS + 1);

  logic [CFG_W-1:0]          cluster_count_r;
  logic [CFG_W-1:0]          dimension_count_r;
  logic [CNTW-1:0]           used_clusters;
  logic [DCW-1:0]            used_dims;
  logic [31:0]               dim_ext;
  logic                      in_fire;
  logic                      pt_live;
  logic                      pt_last;
  logic                      ld_en;
  logic                      rd_en;
  logic                      busy_r;
  logic                      p1_vld_r;
  logic                      p1_fin_r;
  logic signed [COORD_W-1:0] p1_coord_r;
  logic                      p2_vld_r;
  logic                      p2_fin_r;
  logic                      p3_vld_r;
  logic                      p3_fin_r;
  logic                      tok_start_r;
  logic                      out_valid_r;
  logic [ID_W-1:0]           out_cluster_id_r;
  pipe_ctl_t                 ctl;

  logic                      tok_vld  [MAX_CLUSTERS+1];
  logic                      tok_have [MAX_CLUSTERS+1];
  logic [SUM_W-1:0]          tok_sum  [MAX_CLUSTERS+1];
  logic [CIW-1:0]            tok_idx  [MAX_CLUSTERS+1];

  // Counts outside the supported range are clamped when used.
  always_comb begin
    if (cluster_count_r == '0) begin
      used_clusters = CNTW'(1);
    end else if (32'(cluster_count_r) > 32'(MAX_CLUSTERS)) begin
      used_clusters = CNTW'(MAX_CLUSTERS);
    end else begin
      used_clusters = CNTW'(cluster_count_r);
    end
    if (dimension_count_r == '0) begin
      used_dims = DCW'(1);
    end else if (32'(dimension_count_r) > 32'(MAX_DIMS)) begin
      used_dims = DCW'(MAX_DIMS);
    end else begin
      used_dims = DCW'(dimension_count_r);
    end
  end

  assign dim_ext = 32'(in_dim_index);
  assign pt_live = (in_opcode == OP_POINT) && (dim_ext < 32'(used_dims));
  assign pt_last = (in_opcode == OP_POINT) && (dim_ext == 32'(used_dims) - 32'd1);

  // The finishing transaction waits for the search to end and for the result slot.
  assign in_stall = busy_r || (pt_last && out_valid_r);
  assign in_fire  = in_valid && !in_stall;
  assign ld_en    = in_fire && (in_opcode == OP_LOAD) && (dim_ext < 32'(MAX_DIMS));
  assign rd_en    = in_fire && pt_live;

  assign ctl.diff_en = p1_vld_r;
  assign ctl.sq_en   = p2_vld_r;
  assign ctl.acc_en  = p3_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cluster_count_r   <= CFG_W'(1);
      dimension_count_r <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CLUSTER_COUNT:   cluster_count_r   <= cfg_data;
        REG_DIMENSION_COUNT: dimension_count_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      p1_coord_r <= in_coord_value;
    end
    if (tok_vld[MAX_CLUSTERS]) begin
      out_cluster_id_r <= ID_W'(32'(tok_idx[MAX_CLUSTERS]) + 32'd1);
    end
    p1_fin_r <= pt_last;
    p2_fin_r <= p1_fin_r;
    p3_fin_r <= p2_fin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      p3_vld_r    <= 1'b0;
      tok_start_r <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_vld_r    <= rd_en;
      p2_vld_r    <= p1_vld_r;
      p3_vld_r    <= p2_vld_r;
      tok_start_r <= p3_vld_r && p3_fin_r;
      if (in_fire && pt_last) begin
        busy_r <= 1'b1;
      end else if (tok_vld[MAX_CLUSTERS]) begin
        busy_r <= 1'b0;
      end
      if (tok_vld[MAX_CLUSTERS]) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The token enters the chain empty; each cell keeps the smaller sum and its index.
  assign tok_vld[0]  = tok_start_r;
  assign tok_have[0] = 1'b0;
  assign tok_sum[0]  = '0;
  assign tok_idx[0]  = '0;

  for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_chain
    nca_cell #(
      .CELL_ID  (k),
      .MAX_DIMS (MAX_DIMS),
      .CIW      (CIW),
      .CNTW     (CNTW)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .used_clusters (used_clusters),
      .ld_en         (ld_en),
      .ld_cluster    (in_cluster_index),
      .rd_en         (rd_en),
      .addr          (AW'(dim_ext)),
      .item_value    (in_coord_value),
      .ctl           (ctl),
      .p1_coord      (p1_coord_r),
      .tok_vld_i     (tok_vld[k]),
      .tok_have_i    (tok_have[k]),
      .tok_sum_i     (tok_sum[k]),
      .tok_idx_i     (tok_idx[k]),
      .tok_vld_o     (tok_vld[k+1]),
      .tok_have_o    (tok_have[k+1]),
      .tok_sum_o     (tok_sum[k+1]),
      .tok_idx_o     (tok_idx[k+1])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_cluster_id = out_cluster_id_r;

endmodule

/* hdl/nca_checker.sv */
module nca_checker import nca_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic [ID_W-1:0] out_cluster_id
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cluster_id))
    else $error("result changed or vanished while stalled");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input held off after reset");

  // A new result only comes out of a search, during which input is held off.
  a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a preceding search");

endmodule

bind nearest_centroid_assign_unit nca_checker u_nca_checker (.*);
